@@ sv/binary_max_heap_queue_assert.svh @@
// ----------------------------------------------------------------------------
// binary max heap queue assertion macros
// shared property wrappers, clocked on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef BINARY_MAX_HEAP_QUEUE_ASSERT_SVH
`define BINARY_MAX_HEAP_QUEUE_ASSERT_SVH

// condition holds in the same cycle
`define BMHQ_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bmhq assertion failed");

// condition holds in the following cycle
`define BMHQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bmhq assertion failed");

`endif

@@ sv/bmhq_pkg.sv @@
// ----------------------------------------------------------------------------
// bmhq_pkg
// types and constants shared by the priority queue cells and top level
// ----------------------------------------------------------------------------
`default_nettype none

package bmhq_pkg;

	localparam int HEAP_DEPTH = 1024;
	localparam int KEY_W      = 31;
	localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);

	localparam logic [1:0] OP_PUSH  = 2'd0;
	localparam logic [1:0] OP_POP   = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	typedef struct packed {
		logic [1:0]       opcode;
		logic [KEY_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic [KEY_W-1:0] popped_value;
		logic             was_empty;
		logic             was_full;
		logic [CNT_W-1:0] entry_count;
	} rsp_t;

	// broadcast to every cell
	typedef struct packed {
		logic             push;
		logic             pop;
		logic             clear;
		logic [KEY_W-1:0] key;
	} cell_ctl_t;

	// what one cell shows its neighbors
	typedef struct packed {
		logic             occupied;
		logic [KEY_W-1:0] key;
		logic             ge;
	} link_t;

endpackage

`default_nettype wire

@@ sv/binary_max_heap_queue.sv @@
// ----------------------------------------------------------------------------
// binary max heap queue
// the start transfer is registered into valid_s1, then the result into done_q and rsp_q;
// one operation per cycle, every operation finishes in one pass over the chain of cells
// busy is never raised and the receiver cannot stall the result
// reset empties the queue; stored keys are not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module binary_max_heap_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	output logic                busy,
	input  bmhq_pkg::cmd_t      cmd,
	output logic                done,
	output bmhq_pkg::rsp_t      rsp
);

	localparam logic [bmhq_pkg::CNT_W-1:0] FULL_CNT = bmhq_pkg::CNT_W'(bmhq_pkg::HEAP_DEPTH);
	localparam logic [bmhq_pkg::CNT_W-1:0] ONE_CNT  = bmhq_pkg::CNT_W'(1);

	logic                          valid_s1;
	bmhq_pkg::cmd_t                cmd_s1;
	logic [bmhq_pkg::CNT_W-1:0]    count_q;
	logic [bmhq_pkg::CNT_W-1:0]    count_nxt;
	logic                          is_full;
	logic                          is_empty;
	logic                          push_ok;
	logic                          pop_ok;
	bmhq_pkg::cell_ctl_t           ctl;
	bmhq_pkg::link_t               links [bmhq_pkg::HEAP_DEPTH];
	bmhq_pkg::link_t               head_link;
	bmhq_pkg::link_t               tail_link;
	logic                          done_q;
	bmhq_pkg::rsp_t                rsp_q;

	assign busy = 1'b0;

	// input stage: register the command before it fans out to the cells
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s1 <= cmd;
		end
	end

	assign is_full  = (count_q == FULL_CNT);
	assign is_empty = (count_q == '0);
	assign push_ok  = valid_s1 && (cmd_s1.opcode == bmhq_pkg::OP_PUSH) && !is_full;
	assign pop_ok   = valid_s1 && (cmd_s1.opcode == bmhq_pkg::OP_POP) && !is_empty;

	assign ctl.push  = push_ok;
	assign ctl.pop   = pop_ok;
	assign ctl.clear = valid_s1 && (cmd_s1.opcode == bmhq_pkg::OP_CLEAR);
	assign ctl.key   = cmd_s1.value;

	always_comb begin
		count_nxt = count_q;
		if (ctl.clear) begin
			count_nxt = '0;
		end else if (push_ok) begin
			count_nxt = count_q + ONE_CNT;
		end else if (pop_ok) begin
			count_nxt = count_q - ONE_CNT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_nxt;
		end
	end

	// chain ends: an occupied max-key sentinel before the head that never takes the new key, an empty slot after the tail
	assign head_link.occupied = 1'b1;
	assign head_link.key      = '1;
	assign head_link.ge       = 1'b0;
	assign tail_link.occupied = 1'b0;
	assign tail_link.key      = '0;
	assign tail_link.ge       = 1'b1;

	for (genvar i = 0; i < bmhq_pkg::HEAP_DEPTH; i++) begin : g_cell
		bmhq_pkg::link_t prev_l;
		bmhq_pkg::link_t next_l;

		if (i == 0) begin : g_head
			assign prev_l = head_link;
		end else begin : g_mid_prev
			assign prev_l = links[i-1];
		end

		if (i == bmhq_pkg::HEAP_DEPTH - 1) begin : g_tail
			assign next_l = tail_link;
		end else begin : g_mid_next
			assign next_l = links[i+1];
		end

		bmhq_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.prev   (prev_l),
			.next   (next_l),
			.own    (links[i])
		);
	end

	// result register, one strobe per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			rsp_q.popped_value <= pop_ok ? links[0].key : '0;
			rsp_q.was_empty    <= (cmd_s1.opcode == bmhq_pkg::OP_POP) && is_empty;
			rsp_q.was_full     <= (cmd_s1.opcode == bmhq_pkg::OP_PUSH) && is_full;
			rsp_q.entry_count  <= count_nxt;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

`include "binary_max_heap_queue_assert.svh"

	`BMHQ_ASSERT_SAME(a_head_matches_count, 1'b1, links[0].occupied == !is_empty)
	`BMHQ_ASSERT_SAME(a_tail_matches_count, 1'b1, links[bmhq_pkg::HEAP_DEPTH-1].occupied == is_full)
	`BMHQ_ASSERT_SAME(a_full_flag_count, done_q && rsp_q.was_full, rsp_q.entry_count == FULL_CNT)
	`BMHQ_ASSERT_SAME(a_empty_flag_zero, done_q && rsp_q.was_empty, rsp_q.popped_value == '0 && rsp_q.entry_count == '0)
	`BMHQ_ASSERT_NEXT(a_cmd_reaches_s1, start && !busy, valid_s1)

endmodule

`default_nettype wire

@@ sv/bmhq_cell.sv @@
// ----------------------------------------------------------------------------
// bmhq_cell
// one slot of the sorted key chain; shifts toward the tail on insert and
// toward the head on removal
// ----------------------------------------------------------------------------
`default_nettype none

module bmhq_cell (
	input  wire                     clk,
	input  wire                     arst_n,
	input  bmhq_pkg::cell_ctl_t     ctl,
	input  bmhq_pkg::link_t         prev,
	input  bmhq_pkg::link_t         next,
	output bmhq_pkg::link_t         own
);

	logic                       occ_q;
	logic [bmhq_pkg::KEY_W-1:0] key_q;
	logic                       ge;

	// new key goes at or before this slot
	assign ge = !occ_q || (ctl.key > key_q);

	assign own.occupied = occ_q;
	assign own.key      = key_q;
	assign own.ge       = ge;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (ctl.clear) begin
			occ_q <= 1'b0;
		end else if (ctl.push) begin
			if (ge && prev.ge) begin
				occ_q <= prev.occupied;
			end else if (ge) begin
				occ_q <= 1'b1;
			end
		end else if (ctl.pop) begin
			occ_q <= next.occupied;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push && !ctl.clear) begin
			if (ge && prev.ge) begin
				key_q <= prev.key;
			end else if (ge) begin
				key_q <= ctl.key;
			end
		end else if (ctl.pop && !ctl.clear) begin
			key_q <= next.key;
		end
	end

endmodule

`default_nettype wire
